// File: sv/lik_pkg.sv
// ----------------------------------------------------------------------------
// lik_pkg: shared constants and helpers for the limb inverse kinematics solver
// Fixed widths of the CORDIC datapaths, the arctangent table and the angle
// output conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package lik_pkg;

   localparam int STEPS       = 16;  // CORDIC iterations
   localparam int ATAN_IN_W   = 36;  // atan2 operand width, Q20.16
   localparam int ATAN_CW     = 55;  // atan2 working width (operand << 16 plus growth)
   localparam int ANG_W       = 21;  // internal angle, Q16 radians
   localparam int CS_W        = 33;  // sin/cos working width, Q2.30
   localparam int TRIG_W      = 32;  // clamped sin/cos, Q2.30
   localparam int NUM_W       = 36;  // dividend width, Q20.16
   localparam int QUOT_W      = 32;  // saturated quotient, Q16.16
   localparam int POS_W       = 32;  // input coordinate, Q16.16
   localparam int ANG_OUT_W   = 16;  // output angle, Q3.13

   localparam logic signed [ANG_W-1:0] PI_Q16      = 21'sd205887;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 21'sd102944;
   localparam logic signed [CS_W-1:0]  CORDIC_K_Q30 = 33'sd652032874;
   localparam logic signed [CS_W-1:0]  ONE_Q30      = 33'sd1073741824;
   localparam logic signed [TRIG_W-1:0] HALF_Q30    = 32'sd536870912;

   // atan(2^-i) in Q16
   function automatic logic signed [ANG_W-1:0] atan_tab(input logic [3:0] idx);
      logic signed [ANG_W-1:0] r;
      case (idx)
         4'd0:    r = 21'sd51472;
         4'd1:    r = 21'sd30386;
         4'd2:    r = 21'sd16055;
         4'd3:    r = 21'sd8150;
         4'd4:    r = 21'sd4091;
         4'd5:    r = 21'sd2047;
         4'd6:    r = 21'sd1024;
         4'd7:    r = 21'sd512;
         4'd8:    r = 21'sd256;
         4'd9:    r = 21'sd128;
         4'd10:   r = 21'sd64;
         4'd11:   r = 21'sd32;
         4'd12:   r = 21'sd16;
         4'd13:   r = 21'sd8;
         4'd14:   r = 21'sd4;
         4'd15:   r = 21'sd2;
         default: r = 21'sd0;
      endcase
      return r;
   endfunction

   // Q16 angle to Q3.13 with rounding and saturation
   function automatic logic signed [ANG_OUT_W-1:0] out_angle(
      input logic signed [ANG_W-1:0] z);
      logic signed [ANG_W:0]   r;
      logic signed [ANG_W-3:0] q;
      logic signed [ANG_OUT_W-1:0] o;
      r = (ANG_W+1)'(z) + 22'sd4;
      q = signed'(r[ANG_W:3]);
      if (q > 19'sd32767) begin
         o = 16'sh7FFF;
      end else if (q < -19'sd32768) begin
         o = 16'sh8000;
      end else begin
         o = 16'(q);
      end
      return o;
   endfunction

endpackage

`default_nettype wire

// File: sv/limb_inverse_kinematics_top.sv
// ----------------------------------------------------------------------------
// limb_inverse_kinematics_top: two-segment limb inverse kinematics solver
// Solves the four joint angles from elbow and wrist positions with a chain
// of pipelined CORDIC, divider and rotation units.
//
//   Channel  Direction  Contents
//   req_     in         tdata: elbow x,y,z, wrist x,y,z; tuser: left side
//   rsp_     out        tdata: root yaw, root roll, root pitch, middle bend
//   csr_     in         upper segment length, write only
//
// One word enters per cycle unless a result is held; a word passes through
// four arctangent units, three sine/cosine units, two dividers, the rotation
// unit and the output register.
// Reset clears the valid bits in every stage and the length register.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module limb_inverse_kinematics_top (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // elbow_x, elbow_y, elbow_z, wrist_x, wrist_y, wrist_z (32 bits each)
   input  wire logic [191:0]  req_tdata,
   // left_side
   input  wire logic          req_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // root_yaw, root_roll, root_pitch, middle_bend (16 bits each)
   output logic [63:0]        rsp_tdata,
   input  wire logic          csr_wr_en,
   input  wire logic [30:0]   csr_wr_data
);

   localparam int AW = lik_pkg::ATAN_IN_W;
   localparam int NW = lik_pkg::NUM_W;
   localparam int GW = lik_pkg::ANG_W;
   localparam int TW = lik_pkg::TRIG_W;

   typedef struct packed {
      logic signed [31:0] ex;
      logic signed [31:0] ey;
      logic signed [32:0] ez;
      logic signed [31:0] wx;
      logic signed [31:0] wy;
      logic signed [32:0] wz;
   } pos_type;

   typedef struct packed {
      logic signed [GW-1:0] a1;
      pos_type              p;
   } sc1_type;

   typedef struct packed {
      logic signed [GW-1:0] a1;
      logic signed [TW-1:0] s1;
      logic signed [TW-1:0] c1;
      logic signed [32:0]   ez;
      logic signed [31:0]   wx;
      logic signed [31:0]   wy;
      logic signed [32:0]   wz;
   } dv1_type;

   typedef struct packed {
      logic signed [GW-1:0] a1;
      logic signed [TW-1:0] s1;
      logic signed [TW-1:0] c1;
      logic signed [31:0]   wx;
      logic signed [31:0]   wy;
      logic signed [32:0]   wz;
   } at2_type;

   typedef struct packed {
      logic signed [GW-1:0] a1;
      logic signed [GW-1:0] a2;
      logic signed [TW-1:0] s1;
      logic signed [TW-1:0] c1;
      logic signed [31:0]   wx;
      logic signed [31:0]   wy;
      logic signed [32:0]   wz;
   } sc2_type;

   typedef struct packed {
      logic signed [GW-1:0] a1;
      logic signed [GW-1:0] a2;
   } ang2_type;

   typedef struct packed {
      logic signed [GW-1:0] a1;
      logic signed [GW-1:0] a2;
      logic signed [34:0]   w2x;
      logic signed [34:0]   w2y;
      logic signed [34:0]   w2z;
   } at3_type;

   typedef struct packed {
      logic signed [GW-1:0] a1;
      logic signed [GW-1:0] a2;
      logic signed [GW-1:0] a3;
      logic signed [34:0]   w2x;
      logic signed [34:0]   w2y;
      logic signed [34:0]   w2z;
   } sc3_type;

   typedef struct packed {
      logic signed [GW-1:0] a1;
      logic signed [GW-1:0] a2;
      logic signed [GW-1:0] a3;
      logic signed [34:0]   w2y;
   } dv2_type;

   typedef struct packed {
      logic signed [GW-1:0] a1;
      logic signed [GW-1:0] a2;
      logic signed [GW-1:0] a3;
   } ang3_type;

   logic               en;
   logic [30:0]        upper_length_ff;
   logic               rsp_tvalid_ff;
   logic [63:0]        rsp_tdata_ff;

   pos_type            pos_in;
   logic signed [31:0] ez_raw, wz_raw;

   logic               v1, v2, v3, v4, v5, v6, v7, v8, v9, v10;
   pos_type            at1_side;
   logic signed [GW-1:0] a1_z, a2_z, a3_z, a5_z;
   sc1_type            sc1_side_in, sc1_side;
   logic signed [TW-1:0] s1, c1, s2, c2, s3, c3;
   logic               sel1, sel3;
   dv1_type            dv1_side_in, dv1_side;
   logic signed [TW-1:0] d_q, n_q;
   at2_type            at2_side_in, at2_side;
   sc2_type            sc2_side_in, sc2_side;
   ang2_type           rot_side_in, rot_side;
   logic signed [34:0] w2x, w2y, w2z;
   at3_type            at3_side_in, at3_side;
   sc3_type            sc3_side_in, sc3_side;
   dv2_type            dv2_side_in, dv2_side;
   ang3_type           at4_side_in, at4_side;
   logic signed [AW-1:0] at4_x;

   // Whole pipeline advances unless a result is held
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   // Length register
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_length_ff <= '0;
      end else if (csr_wr_en) begin
         upper_length_ff <= csr_wr_data;
      end
   end

   // Unpack the word and mirror z on the left side
   always_comb begin
      ez_raw    = signed'(req_tdata[95:64]);
      wz_raw    = signed'(req_tdata[191:160]);
      pos_in.ex = signed'(req_tdata[31:0]);
      pos_in.ey = signed'(req_tdata[63:32]);
      pos_in.ez = req_tuser ? -33'(ez_raw) : 33'(ez_raw);
      pos_in.wx = signed'(req_tdata[127:96]);
      pos_in.wy = signed'(req_tdata[159:128]);
      pos_in.wz = req_tuser ? -33'(wz_raw) : 33'(wz_raw);
   end

   // q1 = atan2(-ex, ey)
   lik_atan2 #(.SW($bits(pos_type))) u_atan_q1 (
      .clock, .reset, .en,
      .in_valid (req_tvalid && req_tready),
      .in_y     (-AW'(pos_in.ex)),
      .in_x     (AW'(pos_in.ey)),
      .in_side  (pos_in),
      .out_valid(v1),
      .out_z    (a1_z),
      .out_side (at1_side)
   );

   assign sc1_side_in = '{a1: a1_z, p: at1_side};

   lik_sincos #(.SW($bits(sc1_type))) u_sc_q1 (
      .clock, .reset, .en,
      .in_valid (v1),
      .in_a     (a1_z),
      .in_side  (sc1_side_in),
      .out_valid(v2),
      .out_sin  (s1),
      .out_cos  (c1),
      .out_side (sc1_side)
   );

   // Pick the better conditioned divisor for the roll projection
   assign sel1 = (s1 > lik_pkg::HALF_Q30) || (s1 < -lik_pkg::HALF_Q30);
   assign dv1_side_in = '{a1: sc1_side.a1, s1: s1, c1: c1, ez: sc1_side.p.ez,
                          wx: sc1_side.p.wx, wy: sc1_side.p.wy, wz: sc1_side.p.wz};

   lik_div #(.SW($bits(dv1_type))) u_div_d (
      .clock, .reset, .en,
      .in_valid (v2),
      .in_num   (sel1 ? -NW'(sc1_side.p.ex) : NW'(sc1_side.p.ey)),
      .in_den   (sel1 ? s1 : c1),
      .in_side  (dv1_side_in),
      .out_valid(v3),
      .out_q    (d_q),
      .out_side (dv1_side)
   );

   assign at2_side_in = '{a1: dv1_side.a1, s1: dv1_side.s1, c1: dv1_side.c1,
                          wx: dv1_side.wx, wy: dv1_side.wy, wz: dv1_side.wz};

   // q2 = atan2(ez, d)
   lik_atan2 #(.SW($bits(at2_type))) u_atan_q2 (
      .clock, .reset, .en,
      .in_valid (v3),
      .in_y     (AW'(dv1_side.ez)),
      .in_x     (AW'(d_q)),
      .in_side  (at2_side_in),
      .out_valid(v4),
      .out_z    (a2_z),
      .out_side (at2_side)
   );

   assign sc2_side_in = '{a1: at2_side.a1, a2: a2_z, s1: at2_side.s1, c1: at2_side.c1,
                          wx: at2_side.wx, wy: at2_side.wy, wz: at2_side.wz};

   lik_sincos #(.SW($bits(sc2_type))) u_sc_q2 (
      .clock, .reset, .en,
      .in_valid (v4),
      .in_a     (a2_z),
      .in_side  (sc2_side_in),
      .out_valid(v5),
      .out_sin  (s2),
      .out_cos  (c2),
      .out_side (sc2_side)
   );

   assign rot_side_in = '{a1: sc2_side.a1, a2: sc2_side.a2};

   // Wrist into the frame after q1 and q2
   lik_rot #(.SW($bits(ang2_type))) u_rot (
      .clock, .reset, .en,
      .in_valid (v5),
      .in_s1    (sc2_side.s1),
      .in_c1    (sc2_side.c1),
      .in_s2    (s2),
      .in_c2    (c2),
      .in_wx    (33'(sc2_side.wx)),
      .in_wy    (33'(sc2_side.wy)),
      .in_wz    (sc2_side.wz),
      .in_side  (rot_side_in),
      .out_valid(v6),
      .out_w2x  (w2x),
      .out_w2y  (w2y),
      .out_w2z  (w2z),
      .out_side (rot_side)
   );

   assign at3_side_in = '{a1: rot_side.a1, a2: rot_side.a2, w2x: w2x, w2y: w2y, w2z: w2z};

   // q3 = atan2(w2z, -w2x)
   lik_atan2 #(.SW($bits(at3_type))) u_atan_q3 (
      .clock, .reset, .en,
      .in_valid (v6),
      .in_y     (AW'(w2z)),
      .in_x     (-AW'(w2x)),
      .in_side  (at3_side_in),
      .out_valid(v7),
      .out_z    (a3_z),
      .out_side (at3_side)
   );

   assign sc3_side_in = '{a1: at3_side.a1, a2: at3_side.a2, a3: a3_z,
                          w2x: at3_side.w2x, w2y: at3_side.w2y, w2z: at3_side.w2z};

   lik_sincos #(.SW($bits(sc3_type))) u_sc_q3 (
      .clock, .reset, .en,
      .in_valid (v7),
      .in_a     (a3_z),
      .in_side  (sc3_side_in),
      .out_valid(v8),
      .out_sin  (s3),
      .out_cos  (c3),
      .out_side (sc3_side)
   );

   assign sel3 = (s3 > lik_pkg::HALF_Q30) || (s3 < -lik_pkg::HALF_Q30);
   assign dv2_side_in = '{a1: sc3_side.a1, a2: sc3_side.a2, a3: sc3_side.a3,
                          w2y: sc3_side.w2y};

   lik_div #(.SW($bits(dv2_type))) u_div_n (
      .clock, .reset, .en,
      .in_valid (v8),
      .in_num   (sel3 ? NW'(sc3_side.w2z) : -NW'(sc3_side.w2x)),
      .in_den   (sel3 ? s3 : c3),
      .in_side  (dv2_side_in),
      .out_valid(v9),
      .out_q    (n_q),
      .out_side (dv2_side)
   );

   assign at4_side_in = '{a1: dv2_side.a1, a2: dv2_side.a2, a3: dv2_side.a3};
   assign at4_x       = AW'(dv2_side.w2y) - signed'(AW'(upper_length_ff));

   // q5 = atan2(n, w2y - upper_length)
   lik_atan2 #(.SW($bits(ang3_type))) u_atan_q5 (
      .clock, .reset, .en,
      .in_valid (v9),
      .in_y     (AW'(n_q)),
      .in_x     (at4_x),
      .in_side  (at4_side_in),
      .out_valid(v10),
      .out_z    (a5_z),
      .out_side (at4_side)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= v10;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= {lik_pkg::out_angle(a5_z), lik_pkg::out_angle(at4_side.a3),
                          lik_pkg::out_angle(at4_side.a2), lik_pkg::out_angle(at4_side.a1)};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire

// File: sv/lik_atan2.sv
// ----------------------------------------------------------------------------
// lik_atan2: pipelined vectoring CORDIC arctangent
// One register stage for the quadrant fold, then one per CORDIC step.
// A sideband word travels along with each item.
// ----------------------------------------------------------------------------
`default_nettype none

module lik_atan2 #(
   parameter int SW = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                en,
   input  wire logic                                in_valid,
   input  wire logic signed [lik_pkg::ATAN_IN_W-1:0] in_y,
   input  wire logic signed [lik_pkg::ATAN_IN_W-1:0] in_x,
   input  wire logic [SW-1:0]                       in_side,
   output logic                                     out_valid,
   output logic signed [lik_pkg::ANG_W-1:0]         out_z,
   output logic [SW-1:0]                            out_side
);

   localparam int CW = lik_pkg::ATAN_CW;
   localparam int AW = lik_pkg::ANG_W;
   localparam int NS = lik_pkg::STEPS;

   logic [NS:0]              v_ff;
   logic signed [CW-1:0]     x_ff    [0:NS];
   logic signed [CW-1:0]     y_ff    [0:NS];
   logic signed [AW-1:0]     z_ff    [0:NS];
   logic                     zero_ff [0:NS];
   logic [SW-1:0]            side_ff [0:NS];

   logic signed [CW-1:0]     xs_in, ys_in, x0_in, y0_in;
   logic signed [AW-1:0]     z0_in;

   // Scale by 2^16 and fold the left half plane
   always_comb begin
      xs_in = CW'(in_x) <<< 16;
      ys_in = CW'(in_y) <<< 16;
      if (in_x < 0) begin
         x0_in = -xs_in;
         y0_in = -ys_in;
         z0_in = (in_y >= 0) ? lik_pkg::PI_Q16 : -lik_pkg::PI_Q16;
      end else begin
         x0_in = xs_in;
         y0_in = ys_in;
         z0_in = '0;
      end
   end

   // Valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NS-1:0], in_valid};
      end
   end

   // Fold stage
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         zero_ff[0] <= (in_x == 0) && (in_y == 0);
         side_ff[0] <= in_side;
      end
   end

   // Vectoring steps, one per stage
   for (genvar i = 0; i < NS; i++) begin : g_step
      logic signed [CW-1:0] x_in, y_in;
      logic signed [AW-1:0] z_in;
      always_comb begin
         if (y_ff[i] >= 0) begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + lik_pkg::atan_tab(4'(i));
         end else begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - lik_pkg::atan_tab(4'(i));
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
            zero_ff[i+1] <= zero_ff[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   // Degenerate origin gives zero
   assign out_valid = v_ff[NS];
   assign out_z     = zero_ff[NS] ? '0 : z_ff[NS];
   assign out_side  = side_ff[NS];

endmodule

`default_nettype wire

// File: sv/lik_sincos.sv
// ----------------------------------------------------------------------------
// lik_sincos: pipelined rotation CORDIC sine and cosine
// Range fold stage, one stage per CORDIC step, then a sign and clamp stage.
// Results are Q2.30 clamped to plus or minus one.
// ----------------------------------------------------------------------------
`default_nettype none

module lik_sincos #(
   parameter int SW = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  wire logic                              in_valid,
   input  wire logic signed [lik_pkg::ANG_W-1:0]  in_a,
   input  wire logic [SW-1:0]                     in_side,
   output logic                                   out_valid,
   output logic signed [lik_pkg::TRIG_W-1:0]      out_sin,
   output logic signed [lik_pkg::TRIG_W-1:0]      out_cos,
   output logic [SW-1:0]                          out_side
);

   localparam int CW = lik_pkg::CS_W;
   localparam int AW = lik_pkg::ANG_W;
   localparam int TW = lik_pkg::TRIG_W;
   localparam int NS = lik_pkg::STEPS;

   logic [NS+1:0]          v_ff;
   logic signed [CW-1:0]   x_ff    [0:NS];
   logic signed [CW-1:0]   y_ff    [0:NS];
   logic signed [AW-1:0]   a_ff    [0:NS];
   logic                   neg_ff  [0:NS];
   logic [SW-1:0]          side_ff [0:NS];
   logic signed [TW-1:0]   sin_ff, cos_ff;
   logic [SW-1:0]          oside_ff;

   logic signed [AW-1:0]   a0_in;
   logic                   neg0_in;
   logic signed [CW-1:0]   xf_in, yf_in;

   function automatic logic signed [TW-1:0] clamp(input logic signed [CW-1:0] v);
      logic signed [TW-1:0] r;
      if (v > lik_pkg::ONE_Q30) begin
         r = TW'(lik_pkg::ONE_Q30);
      end else if (v < -lik_pkg::ONE_Q30) begin
         r = TW'(-lik_pkg::ONE_Q30);
      end else begin
         r = TW'(v);
      end
      return r;
   endfunction

   // Fold the angle into the right half plane
   always_comb begin
      if (in_a > lik_pkg::HALF_PI_Q16) begin
         a0_in   = in_a - lik_pkg::PI_Q16;
         neg0_in = 1'b1;
      end else if (in_a < -lik_pkg::HALF_PI_Q16) begin
         a0_in   = in_a + lik_pkg::PI_Q16;
         neg0_in = 1'b1;
      end else begin
         a0_in   = in_a;
         neg0_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NS:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= lik_pkg::CORDIC_K_Q30;
         y_ff[0]    <= '0;
         a_ff[0]    <= a0_in;
         neg_ff[0]  <= neg0_in;
         side_ff[0] <= in_side;
      end
   end

   // Rotation steps, one per stage
   for (genvar i = 0; i < NS; i++) begin : g_step
      logic signed [CW-1:0] x_in, y_in;
      logic signed [AW-1:0] a_in;
      always_comb begin
         if (a_ff[i] >= 0) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            a_in = a_ff[i] - lik_pkg::atan_tab(4'(i));
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            a_in = a_ff[i] + lik_pkg::atan_tab(4'(i));
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            a_ff[i+1]    <= a_in;
            neg_ff[i+1]  <= neg_ff[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   // Restore the sign and clamp
   assign xf_in = neg_ff[NS] ? -x_ff[NS] : x_ff[NS];
   assign yf_in = neg_ff[NS] ? -y_ff[NS] : y_ff[NS];

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff   <= clamp(yf_in);
         cos_ff   <= clamp(xf_in);
         oside_ff <= side_ff[NS];
      end
   end

   assign out_valid = v_ff[NS+1];
   assign out_sin   = sin_ff;
   assign out_cos   = cos_ff;
   assign out_side  = oside_ff;

endmodule

`default_nettype wire

// File: sv/lik_div.sv
// ----------------------------------------------------------------------------
// lik_div: pipelined saturating fixed-point divider
// Computes (num * 2^30) / den truncated toward zero, one quotient bit per
// stage by restoring division on magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module lik_div #(
   parameter int SW = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  wire logic                              in_valid,
   input  wire logic signed [lik_pkg::NUM_W-1:0]  in_num,
   input  wire logic signed [lik_pkg::TRIG_W-1:0] in_den,
   input  wire logic [SW-1:0]                     in_side,
   output logic                                   out_valid,
   output logic signed [lik_pkg::QUOT_W-1:0]      out_q,
   output logic [SW-1:0]                          out_side
);

   localparam int NW = lik_pkg::NUM_W;
   localparam int DW = lik_pkg::TRIG_W;
   localparam int OW = lik_pkg::QUOT_W;
   localparam int XW = NW + 30;        // dividend width
   localparam int QB = 38;             // quotient bits produced

   logic [QB+1:0]    v_ff;
   logic [DW-1:0]    rem_ff  [0:QB];
   logic [QB-1:0]    q_ff    [0:QB];
   logic [QB-1:0]    dvd_ff  [0:QB];
   logic [DW-1:0]    dmag_ff [0:QB];
   logic             neg_ff  [0:QB];
   logic             dz_ff   [0:QB];
   logic [SW-1:0]    side_ff [0:QB];
   logic signed [OW-1:0] q_out_ff;
   logic [SW-1:0]    oside_ff;

   logic [NW-1:0]    nmag_in;
   logic [DW-1:0]    dmag_in;
   logic [XW-1:0]    dividend_in;
   logic signed [OW-1:0] sat_in;

   // Magnitudes and sign
   always_comb begin
      nmag_in     = in_num[NW-1] ? NW'(-in_num) : NW'(in_num);
      dmag_in     = in_den[DW-1] ? DW'(-in_den) : DW'(in_den);
      dividend_in = {nmag_in, 30'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[QB:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= DW'(dividend_in[XW-1:QB]);
         q_ff[0]    <= '0;
         dvd_ff[0]  <= dividend_in[QB-1:0];
         dmag_ff[0] <= dmag_in;
         neg_ff[0]  <= in_num[NW-1] ^ in_den[DW-1];
         dz_ff[0]   <= (in_den == 0);
         side_ff[0] <= in_side;
      end
   end

   // One quotient bit per stage, high bit first
   for (genvar k = 0; k < QB; k++) begin : g_bit
      logic [DW:0]   r2_in;
      logic [DW-1:0] rem_in;
      logic          qb_in;
      always_comb begin
         r2_in = {rem_ff[k], dvd_ff[k][QB-1-k]};
         if (r2_in >= {1'b0, dmag_ff[k]}) begin
            rem_in = DW'(r2_in - {1'b0, dmag_ff[k]});
            qb_in  = 1'b1;
         end else begin
            rem_in = DW'(r2_in);
            qb_in  = 1'b0;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_in;
            q_ff[k+1]    <= {q_ff[k][QB-2:0], qb_in};
            dvd_ff[k+1]  <= dvd_ff[k];
            dmag_ff[k+1] <= dmag_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            dz_ff[k+1]   <= dz_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   // Apply sign and saturate to Q16.16
   always_comb begin
      if (dz_ff[QB]) begin
         sat_in = '0;
      end else if (!neg_ff[QB]) begin
         sat_in = (q_ff[QB] > 38'd2147483647) ? 32'sh7FFF_FFFF : signed'(OW'(q_ff[QB]));
      end else begin
         sat_in = (q_ff[QB] > 38'd2147483648) ? 32'sh8000_0000 :
                  signed'(OW'(~q_ff[QB] + 38'd1));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_out_ff <= sat_in;
         oside_ff <= side_ff[QB];
      end
   end

   assign out_valid = v_ff[QB+1];
   assign out_q     = q_out_ff;
   assign out_side  = oside_ff;

endmodule

`default_nettype wire

// File: sv/lik_rot.sv
// ----------------------------------------------------------------------------
// lik_rot: wrist rotation Rx(-q2) Rz(-q1)
// Four stages: products, rounded sums, products, rounded sums.
// Products are Q16.16 by Q2.30, each sum rounded back to Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module lik_rot #(
   parameter int SW = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  wire logic                              in_valid,
   input  wire logic signed [lik_pkg::TRIG_W-1:0] in_s1,
   input  wire logic signed [lik_pkg::TRIG_W-1:0] in_c1,
   input  wire logic signed [lik_pkg::TRIG_W-1:0] in_s2,
   input  wire logic signed [lik_pkg::TRIG_W-1:0] in_c2,
   input  wire logic signed [32:0]                in_wx,
   input  wire logic signed [32:0]                in_wy,
   input  wire logic signed [32:0]                in_wz,
   input  wire logic [SW-1:0]                     in_side,
   output logic                                   out_valid,
   output logic signed [34:0]                     out_w2x,
   output logic signed [34:0]                     out_w2y,
   output logic signed [34:0]                     out_w2z,
   output logic [SW-1:0]                          out_side
);

   localparam int TW = lik_pkg::TRIG_W;

   logic [3:0]              v_ff;
   logic signed [64:0]      pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [TW-1:0]    s2a_ff, c2a_ff, s2b_ff, c2b_ff;
   logic signed [32:0]      wza_ff, wzb_ff;
   logic signed [33:0]      w2x_ff, t_ff, w2xb_ff;
   logic signed [65:0]      pe_ff, pf_ff, pg_ff, ph_ff;
   logic signed [34:0]      w2xo_ff, w2y_ff, w2z_ff;
   logic [SW-1:0]           sa_ff, sb_ff, sc_ff, sd_ff;

   logic signed [65:0]      suma_in, sumb_in;
   logic signed [66:0]      sumc_in, sumd_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   // Round sums to Q16.16
   always_comb begin
      suma_in = 66'(pa_ff) + 66'(pb_ff) + 66'sd536870912;
      sumb_in = 66'(pc_ff) - 66'(pd_ff) + 66'sd536870912;
      sumc_in = 67'(pe_ff) + 67'(pf_ff) + 67'sd536870912;
      sumd_in = 67'(pg_ff) - 67'(ph_ff) + 67'sd536870912;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // first rotation products
         pa_ff   <= in_c1 * in_wx;
         pb_ff   <= in_s1 * in_wy;
         pc_ff   <= in_c1 * in_wy;
         pd_ff   <= in_s1 * in_wx;
         s2a_ff  <= in_s2;
         c2a_ff  <= in_c2;
         wza_ff  <= in_wz;
         sa_ff   <= in_side;
         // first rotation sums
         w2x_ff  <= 34'(suma_in >>> 30);
         t_ff    <= 34'(sumb_in >>> 30);
         s2b_ff  <= s2a_ff;
         c2b_ff  <= c2a_ff;
         wzb_ff  <= wza_ff;
         sb_ff   <= sa_ff;
         // second rotation products
         pe_ff   <= c2b_ff * t_ff;
         pf_ff   <= s2b_ff * wzb_ff;
         pg_ff   <= c2b_ff * wzb_ff;
         ph_ff   <= s2b_ff * t_ff;
         w2xb_ff <= w2x_ff;
         sc_ff   <= sb_ff;
         // second rotation sums
         w2y_ff  <= 35'(sumc_in >>> 30);
         w2z_ff  <= 35'(sumd_in >>> 30);
         w2xo_ff <= 35'(w2xb_ff);
         sd_ff   <= sc_ff;
      end
   end

   assign out_valid = v_ff[3];
   assign out_w2x   = w2xo_ff;
   assign out_w2y   = w2y_ff;
   assign out_w2z   = w2z_ff;
   assign out_side  = sd_ff;

endmodule

`default_nettype wire

// File: sv/lik_checker.sv
// ----------------------------------------------------------------------------
// lik_checker: port-level checks for the limb inverse kinematics solver
// Watches the stream handshakes and the pipeline stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module lik_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata
);

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   // A held result keeps its word
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("held result word changed");

   // A held result stalls the input side
   a_stall: assert property (@(posedge clock)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while pipeline frozen");

   // An empty output stage never blocks the input
   a_flow: assert property (@(posedge clock)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("input blocked with free output stage");

endmodule

bind limb_inverse_kinematics_top lik_checker u_lik_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
